>>> src/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg - shared types and constants for the band steering client table
// Item, entry, result and configuration types, event kind and outcome codes.
// ----------------------------------------------------------------------------
package bst_pkg;

   // table size default
   localparam int TABLE_ENTRIES_DEF = 32;

   // decoupling queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // field widths
   localparam int MAC_W    = 48;
   localparam int FREQ_W   = 16;
   localparam int SIG_W    = 8;
   localparam int TIME_W   = 32;
   localparam int CNT_W    = 8;
   localparam int REM_W    = 6;
   localparam int AGE_W    = 16;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // event kinds as they arrive on the request tuser
   localparam logic [2:0] KIND_LEARN  = 3'd0;
   localparam logic [2:0] KIND_TRY    = 3'd1;
   localparam logic [2:0] KIND_DISC   = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;
   localparam logic [2:0] KIND_CLEAN  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIG_THR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRY_THR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_PRB  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAN_AUTH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAN_AGE  = 3'd6;

   // decoded operation
   typedef enum logic [2:0] {
      OP_LEARN,
      OP_TRY,
      OP_DISC,
      OP_DELETE,
      OP_CLEAN,
      OP_NONE
   } op_type;

   // verdict codes
   typedef enum logic [2:0] {
      OUT_ACC_HIGH  = 3'd0,
      OUT_ACC_THR   = 3'd1,
      OUT_REJ_FORCE = 3'd2,
      OUT_REJ_SIG   = 3'd3,
      OUT_REJ_CNT   = 3'd4,
      OUT_NONE      = 3'd5,
      OUT_FULL      = 3'd6
   } outcome_type;

   typedef struct packed {
      logic [FREQ_W-1:0]        freq_thr;
      logic signed [SIG_W-1:0]  sig_thr;
      logic [CNT_W-1:0]         try_thr;
      logic                     force_mode;
      logic                     force_probe;
      logic                     clean_authed;
      logic [AGE_W-1:0]         clean_age;
   } cfg_type;

   typedef struct packed {
      op_type                   op;
      logic [MAC_W-1:0]         mac;
      logic [FREQ_W-1:0]        freq;
      logic signed [SIG_W-1:0]  sig;
      logic                     auth;
      logic [TIME_W-1:0]        now;
      logic                     high;
   } item_type;

   typedef struct packed {
      logic [MAC_W-1:0]         mac;
      logic [FREQ_W-1:0]        top_freq;
      logic signed [SIG_W-1:0]  sig_lo;
      logic signed [SIG_W-1:0]  sig_hi;
      logic [TIME_W-1:0]        last_seen;
      logic                     authed;
      logic [CNT_W-1:0]         probe_tries;
      logic [CNT_W-1:0]         auth_tries;
      logic                     connected;
   } entry_type;

   // packed so that outcome lands in the lowest bits
   typedef struct packed {
      logic [REM_W-1:0]         removed;
      logic                     conn;
      logic                     found;
      logic [CNT_W-1:0]         attempt;
      outcome_type              outcome;
   } result_type;

   // saturating attempt counter step
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

>>> src/bst_front.sv
// ----------------------------------------------------------------------------
// bst_front - request intake and classification
// Decodes each request into an operation with its band class and holds it in
// a short queue so the intake keeps going while the engine is busy.
// ----------------------------------------------------------------------------
module bst_front (
   input  logic                          clock,
   input  logic                          reset,
   input  bst_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [2:0]                    in_kind,
   input  logic [bst_pkg::REQ_DATA_W-1:0] in_data,
   output logic                          q_valid,
   input  logic                          q_ready,
   output bst_pkg::item_type             q_item
);

   localparam int PTR_W = $clog2(bst_pkg::QUEUE_DEPTH);
   localparam int CNT_QW = $clog2(bst_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(bst_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(bst_pkg::QUEUE_DEPTH - 1);

   bst_pkg::item_type        item_in;
   bst_pkg::item_type        q_ff [bst_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff;
   logic [PTR_W-1:0]         rd_ptr_ff;
   logic [CNT_QW-1:0]        cnt_ff;
   logic                     push;
   logic                     pop;

   // classify the request
   always_comb begin
      item_in.mac  = in_data[47:0];
      item_in.freq = in_data[63:48];
      item_in.sig  = $signed(in_data[71:64]);
      item_in.auth = in_data[72];
      item_in.now  = in_data[104:73];
      item_in.high = (in_data[63:48] > cfg.freq_thr);
      unique case (in_kind)
         bst_pkg::KIND_LEARN:  item_in.op = bst_pkg::OP_LEARN;
         bst_pkg::KIND_TRY:    item_in.op = bst_pkg::OP_TRY;
         bst_pkg::KIND_DISC:   item_in.op = bst_pkg::OP_DISC;
         bst_pkg::KIND_DELETE: item_in.op = bst_pkg::OP_DELETE;
         bst_pkg::KIND_CLEAN:  item_in.op = bst_pkg::OP_CLEAN;
         default:              item_in.op = bst_pkg::OP_NONE;
      endcase
   end

   assign in_ready = (cnt_ff != FULL_CNT);
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = q_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT) else $error("queue count out of range");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |=> (cnt_ff <= CNT_QW'(1))) else $error("queue underflow");

endmodule

>>> src/bst_engine.sv
// ----------------------------------------------------------------------------
// bst_engine - client table scan and update engine
// Scans the entry memory one slot a cycle for lookup, delete and clean, then
// applies the sighting and verdict rules and delivers one result per event.
// ----------------------------------------------------------------------------
module bst_engine #(
   parameter int TABLE_ENTRIES = bst_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bst_pkg::cfg_type     cfg,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  bst_pkg::item_type    q_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bst_pkg::result_type  rsp_res
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [bst_pkg::REM_W-1:0] REM_MAX = {bst_pkg::REM_W{1'b1}};
   // removed count of one for a delete hit
   localparam logic [bst_pkg::REM_W-1:0] REM_ONE = {{(bst_pkg::REM_W-1){1'b0}}, 1'b1};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_HOLD
   } state_type;

   state_type               state_ff;
   bst_pkg::item_type       item_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   bst_pkg::entry_type      mem_ff [TABLE_ENTRIES];
   bst_pkg::entry_type      rdata_ff;
   bst_pkg::entry_type      hold_ff;
   logic [IDX_W-1:0]        addr_ff;
   logic                    issue_ff;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    hit_ff;
   logic [IDX_W-1:0]        slot_ff;
   logic                    have_free_ff;
   logic [IDX_W-1:0]        free_ff;
   logic [bst_pkg::REM_W-1:0] removed_ff;
   logic                    cln_any_ff;
   logic [bst_pkg::TIME_W-1:0] cln_limit_ff;
   bst_pkg::result_type     res_ff;
   bst_pkg::result_type     rsp_ff;
   logic                    rsp_valid_ff;

   logic                    is_lookup;
   logic                    match;
   logic                    last_rd;
   logic                    stale;
   logic                    free_here;
   logic [bst_pkg::REM_W-1:0] removed_nxt;
   logic                    stop;
   logic                    rsp_load;
   bst_pkg::entry_type      upd_entry;
   bst_pkg::result_type     upd_res;
   bst_pkg::result_type     zero_res;

   assign q_ready   = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;
   assign rsp_load  = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   assign is_lookup = (item_ff.op == bst_pkg::OP_LEARN) || (item_ff.op == bst_pkg::OP_TRY) ||
                      (item_ff.op == bst_pkg::OP_DISC);

   // per-entry checks on the data read last cycle
   always_comb begin
      match     = rd_vld_ff && valid_ff[rd_idx_ff] && (rdata_ff.mac == item_ff.mac);
      last_rd   = rd_vld_ff && (rd_idx_ff == LAST_IDX);
      free_here = rd_vld_ff && !valid_ff[rd_idx_ff];
      stale     = rd_vld_ff && valid_ff[rd_idx_ff] && (cfg.clean_authed || !rdata_ff.authed) &&
                  cln_any_ff && (rdata_ff.last_seen < cln_limit_ff);
      removed_nxt = (stale && (removed_ff != REM_MAX)) ? removed_ff + 1'b1 : removed_ff;
      stop      = match && (is_lookup || (item_ff.op == bst_pkg::OP_DELETE));
      zero_res  = '{removed: '0, conn: 1'b0, found: 1'b0, attempt: '0,
                    outcome: bst_pkg::OUT_NONE};
   end

   // sighting, attempt counters and verdict
   always_comb begin
      logic seen_high;
      logic [bst_pkg::CNT_W-1:0] c;
      if (hit_ff) begin
         upd_entry = hold_ff;
      end else begin
         upd_entry = '0;
         upd_entry.mac = item_ff.mac;
      end
      upd_res = zero_res;
      upd_res.found = hit_ff;
      if (upd_entry.top_freq < item_ff.freq) begin
         upd_entry.top_freq = item_ff.freq;
      end
      if (item_ff.high) begin
         upd_entry.sig_hi = item_ff.sig;
      end else begin
         upd_entry.sig_lo = item_ff.sig;
      end
      upd_entry.last_seen = item_ff.now;
      upd_entry.authed    = upd_entry.authed | item_ff.auth;
      seen_high = (upd_entry.top_freq > cfg.freq_thr);
      c = '0;
      if (item_ff.op == bst_pkg::OP_DISC) begin
         upd_entry.connected = 1'b0;
      end else if (item_ff.op == bst_pkg::OP_TRY) begin
         if (item_ff.auth) begin
            upd_entry.auth_tries  = bst_pkg::sat_inc(upd_entry.auth_tries);
            upd_entry.probe_tries = '0;
         end else if (!cfg.force_probe) begin
            upd_entry.probe_tries = bst_pkg::sat_inc(upd_entry.probe_tries);
         end
         c = item_ff.auth ? upd_entry.auth_tries : upd_entry.probe_tries;
         priority if (item_ff.high) begin
            upd_res.outcome = bst_pkg::OUT_ACC_HIGH;
         end else if (seen_high && (cfg.force_mode || (cfg.force_probe && !item_ff.auth))) begin
            upd_res.outcome = bst_pkg::OUT_REJ_FORCE;
         end else if (seen_high && (item_ff.sig > cfg.sig_thr)) begin
            upd_res.outcome = bst_pkg::OUT_REJ_SIG;
         end else if (c > cfg.try_thr) begin
            upd_res.outcome = bst_pkg::OUT_ACC_THR;
         end else begin
            upd_res.outcome = bst_pkg::OUT_REJ_CNT;
            upd_res.attempt = c;
         end
         if ((upd_res.outcome == bst_pkg::OUT_ACC_HIGH) ||
             (upd_res.outcome == bst_pkg::OUT_ACC_THR)) begin
            if (item_ff.auth) begin
               upd_entry.auth_tries = '0;
               upd_entry.connected  = 1'b1;
            end else begin
               upd_entry.probe_tries = '0;
            end
         end
      end
      upd_res.conn = upd_entry.connected;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         mem_ff[slot_ff] <= upd_entry;
      end
      rdata_ff <= mem_ff[addr_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register
         if (rsp_load) begin
            rsp_ff       <= res_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= (state_ff == ST_SCAN) && issue_ff && !stop;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff      <= q_item;
                  hit_ff       <= 1'b0;
                  have_free_ff <= 1'b0;
                  removed_ff   <= '0;
                  addr_ff      <= '0;
                  issue_ff     <= 1'b1;
                  cln_any_ff   <= (q_item.now >= {16'd0, cfg.clean_age});
                  cln_limit_ff <= q_item.now - {16'd0, cfg.clean_age};
                  if (q_item.op == bst_pkg::OP_NONE) begin
                     res_ff   <= zero_res;
                     state_ff <= ST_HOLD;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               // issue the next read while checking the previous one
               rd_idx_ff <= addr_ff;
               if (issue_ff) begin
                  if (addr_ff == LAST_IDX) begin
                     issue_ff <= 1'b0;
                  end else begin
                     addr_ff <= addr_ff + 1'b1;
                  end
               end
               if (free_here && !have_free_ff) begin
                  have_free_ff <= 1'b1;
                  free_ff      <= rd_idx_ff;
               end
               if (item_ff.op == bst_pkg::OP_CLEAN) begin
                  removed_ff <= removed_nxt;
                  if (stale) begin
                     valid_ff[rd_idx_ff] <= 1'b0;
                  end
                  if (last_rd) begin
                     res_ff   <= '{removed: removed_nxt, conn: 1'b0, found: 1'b0,
                                   attempt: '0, outcome: bst_pkg::OUT_NONE};
                     state_ff <= ST_HOLD;
                  end
               end else if (stop) begin
                  if (item_ff.op == bst_pkg::OP_DELETE) begin
                     valid_ff[rd_idx_ff] <= 1'b0;
                     res_ff              <= '{removed: REM_ONE, conn: 1'b0, found: 1'b1,
                                              attempt: '0, outcome: bst_pkg::OUT_NONE};
                     state_ff            <= ST_HOLD;
                  end else begin
                     hit_ff   <= 1'b1;
                     slot_ff  <= rd_idx_ff;
                     hold_ff  <= rdata_ff;
                     state_ff <= ST_UPDATE;
                  end
               end else if (last_rd) begin
                  if (!is_lookup) begin
                     res_ff   <= zero_res;
                     state_ff <= ST_HOLD;
                  end else if (have_free_ff || free_here) begin
                     slot_ff  <= have_free_ff ? free_ff : rd_idx_ff;
                     state_ff <= ST_UPDATE;
                  end else begin
                     res_ff   <= '{removed: '0, conn: 1'b0, found: 1'b0,
                                   attempt: '0, outcome: bst_pkg::OUT_FULL};
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_UPDATE: begin
               valid_ff[slot_ff] <= 1'b1;
               res_ff            <= upd_res;
               state_ff          <= ST_HOLD;
            end
            ST_HOLD: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_new_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) && !hit_ff |-> !valid_ff[slot_ff])
      else $error("insert into an occupied slot");

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) && hit_ff |-> valid_ff[slot_ff])
      else $error("update of an invalid slot");

   a_attempt_only_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.attempt != '0) |-> (rsp_ff.outcome == bst_pkg::OUT_REJ_CNT))
      else $error("attempt count without reject count");

   a_removed_no_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.removed != '0) |-> (rsp_ff.outcome == bst_pkg::OUT_NONE))
      else $error("removal with a verdict");

endmodule

>>> src/band_steering_client_table.sv
// ----------------------------------------------------------------------------
// band_steering_client_table - wireless client table for band steering
// Top level: configuration registers, request front end and table engine.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: tuser carries the event kind, tdata the
// client address, frequency, signal, auth flag and time. Each request gives
// exactly one transfer on the rsp_ stream with the verdict, attempt count,
// found and connected marks and the removed count. Registers are written on
// the csr_ channel, which is always ready. The user must write them only while
// the block is idle; the block itself does not enforce this. Every known event
// scans the entry memory one slot per cycle through its single registered read
// port; a lookup or delete hit ends the scan early. Unknown kinds skip it.
// Events are handled one at a time; a two-entry queue keeps accepting requests
// while the engine works, until it is full. A finished result waits in the
// output register while rsp_tready is low; the engine then holds the next
// result and stops taking queued events. Synchronous reset empties the table
// (all entry valid bits cleared together), empties the queue and restores
// register defaults.
// ----------------------------------------------------------------------------
module band_steering_client_table #(
   parameter int TABLE_ENTRIES = bst_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: mac_address[47:0], frequency[63:48], signal[71:64], is_auth[72],
   //        current_time[104:73], zero fill
   input  logic [bst_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: kind[2:0]
   input  logic [2:0]                      req_tuser,
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: outcome[2:0], attempt_count[10:3], entry_found[11],
   //        is_connected[12], removed_count[18:13], zero fill
   output logic [bst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bst_pkg::CSR_DATA_W-1:0]  csr_data
);

   bst_pkg::cfg_type     cfg_ff;
   logic                 q_valid;
   logic                 q_ready;
   bst_pkg::item_type    q_item;
   bst_pkg::result_type  res;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {5'd0, res};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freq_thr     <= 16'd5000;
         cfg_ff.sig_thr      <= -8'sd80;
         cfg_ff.try_thr      <= 8'd3;
         cfg_ff.force_mode   <= 1'b0;
         cfg_ff.force_probe  <= 1'b0;
         cfg_ff.clean_authed <= 1'b0;
         cfg_ff.clean_age    <= 16'd600;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bst_pkg::CSR_FREQ_THR:   cfg_ff.freq_thr     <= csr_data;
            bst_pkg::CSR_SIG_THR:    cfg_ff.sig_thr      <= $signed(csr_data[7:0]);
            bst_pkg::CSR_TRY_THR:    cfg_ff.try_thr      <= csr_data[7:0];
            bst_pkg::CSR_FORCE:      cfg_ff.force_mode   <= csr_data[0];
            bst_pkg::CSR_FORCE_PRB:  cfg_ff.force_probe  <= csr_data[0];
            bst_pkg::CSR_CLEAN_AUTH: cfg_ff.clean_authed <= csr_data[0];
            bst_pkg::CSR_CLEAN_AGE:  cfg_ff.clean_age    <= csr_data;
            default: ;
         endcase
      end
   end

   bst_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_data  (req_tdata),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item)
   );

   bst_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (res)
   );

endmodule
